>>> rtl/frame_pacing_governor_assert.svh
// Assertion macros used by the frame pacing governor controller.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef FRAME_PACING_GOVERNOR_ASSERT_SVH
`define FRAME_PACING_GOVERNOR_ASSERT_SVH
`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define FPG_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// condition implies consequence in the next cycle
`define FPG_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FPG_ASSERT_IMP(lbl, a, c)
`define FPG_ASSERT_NEXT(lbl, a, c)
`endif
`endif

>>> rtl/fpg_pkg.sv
// Shared types, constants and helpers of the frame pacing governor.
// Depends on nothing.
`timescale 1ns / 1ps
package fpg_pkg;

  localparam logic [3:0]  HOLD_WINDOWS  = 4'd3;
  localparam logic [16:0] SMOOTH_RESET  = 17'd58982;
  localparam logic [23:0] WINDOW_RESET  = 24'd200000;
  localparam logic [16:0] HALF_Q16      = 17'd32768;
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [16:0] MARGIN_Q16    = 17'd13107;
  localparam logic [63:0] NS_PER_S_Q8   = 64'd256000000000;
  localparam logic [39:0] MASK40        = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] MASK48        = 48'hFFFF_FFFF_FFFF;
  localparam logic [23:0] COUNT_MAX     = 24'hFF_FFFF;
  localparam logic [5:0]  DIV_LAST      = 6'd63;
  localparam logic [4:0]  MUL_LAST      = 5'd16;

  // opcodes
  localparam logic [1:0] OPC_COST  = 2'd0;
  localparam logic [1:0] OPC_LOGIC = 2'd1;
  localparam logic [1:0] OPC_PLAN  = 2'd2;
  localparam logic [1:0] OPC_RESET = 2'd3;

  // register indexes
  localparam logic CFG_SMOOTHNESS = 1'b0;
  localparam logic CFG_WINDOW_US  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_COST, ST_CHECK, ST_MEAN, ST_CLOSE, ST_BLEND,
    ST_LOGIC, ST_LOGIC_FIN, ST_PLAN, ST_TICK, ST_NUM, ST_PROD, ST_MAXF,
    ST_CAP, ST_SUB, ST_RESET, ST_EMIT, ST_WAIT
  } ctl_state_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_COST, DP_MEAN_GO, DP_CLOSE, DP_BLEND_FIN,
    DP_LOGIC, DP_LOGIC_FIN, DP_PLAN, DP_TICK_FIN, DP_NUM_FIN, DP_PROD_FIN,
    DP_MAXF_FIN, DP_CAP, DP_SUB_FIN, DP_RESET, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       close;
    logic       logic_div;
    logic       plan_direct;
    logic       tick_le;
    logic       num_lt;
    logic       unit_busy;
    logic       out_free;
  } status_t;

  // steady safety fraction, clamped to 0.5..1.0
  function automatic logic [16:0] steady_f(input logic [16:0] s);
    logic [16:0] r;
    r = s;
    if (r < HALF_Q16) r = HALF_Q16;
    if (r > ONE_Q16)  r = ONE_Q16;
    return r;
  endfunction

  // rising safety fraction, 0.2 below steady with a floor of 0.5
  function automatic logic [16:0] rising_f(input logic [16:0] s);
    logic [16:0] st;
    st = steady_f(s);
    return (st - MARGIN_Q16 > HALF_Q16) ? st - MARGIN_Q16 : HALF_Q16;
  endfunction

endpackage

>>> rtl/fpg_div.sv
// Restoring divider, 64-bit by 64-bit, one quotient bit per cycle.
// Depends on fpg_pkg.
`timescale 1ns / 1ps
module fpg_div import fpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quot
);

  logic [63:0] q_r;
  logic [63:0] rem_r;
  logic [63:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [64:0] trial;
  logic        ge;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_r, q_r[63]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_LAST;
      q_r    <= dividend;
      rem_r  <= '0;
      d_r    <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? 64'(trial - {1'b0, d_r}) : trial[63:0];
      q_r   <= {q_r[62:0], ge};
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

>>> rtl/fpg_mul.sv
// Shift-add multiplier, 64-bit by 17-bit, one multiplier bit per cycle.
// Depends on fpg_pkg.
`timescale 1ns / 1ps
module fpg_mul import fpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] mcand,
  input  logic [16:0] mplier,
  output logic        busy,
  output logic [63:0] prod
);

  logic [63:0] a_r;
  logic [16:0] b_r;
  logic [63:0] acc_r;
  logic [4:0]  cnt_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= MUL_LAST;
      a_r    <= mcand;
      b_r    <= mplier;
      acc_r  <= '0;
    end else if (busy_r) begin
      // add the shifted multiplicand for each set bit
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[62:0], 1'b0};
      b_r <= {1'b0, b_r[16:1]};
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

>>> rtl/fpg_datapath.sv
// Datapath: configuration, governor state, input capture, shared divider,
// multiplier, divide-by-five/ten unit and output register.
// Depends on fpg_pkg, fpg_div, fpg_mul.
`timescale 1ns / 1ps
module fpg_datapath import fpg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output status_t      sts,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_wdata,
  input  logic [1:0]   in_opcode,
  input  logic [31:0]  in_duration_ns,
  input  logic [39:0]  in_now_us,
  input  logic [11:0]  in_target_fps,
  input  logic [7:0]   in_native_fps,
  input  logic [11:0]  in_hard_cap_fps,
  input  logic         in_bypass_budget,
  input  logic         in_force_native,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_plan_valid,
  output logic [11:0]  out_subframes,
  output logic [11:0]  out_pace_fps
);

  // configuration
  logic [16:0] smooth_r;
  logic [23:0] win_r;

  // captured word
  logic [1:0]  opc_r;
  logic [31:0] dur_r;
  logic [39:0] now_r;
  logic [11:0] tgt_in_r;
  logic [7:0]  nat_r;
  logic [11:0] cap_r;
  logic        byp_r;
  logic        frc_r;

  // governor state
  logic [39:0] avg_r;
  logic [39:0] peak_r;
  logic [39:0] lt_r;
  logic [47:0] wsum_r;
  logic [23:0] wcnt_r;
  logic [39:0] wmax_r;
  logic [39:0] wstart_r;
  logic [16:0] safety_r;
  logic [3:0]  hold_r;
  logic        close_r;

  // work and result
  logic [11:0] tgt_r;
  logic        res_plan_r;
  logic [11:0] res_sub_r;
  logic [11:0] res_pace_r;
  logic        out_valid_r;
  logic        out_plan_r;
  logic [11:0] out_sub_r;
  logic [11:0] out_pace_r;

  // units
  logic        div_start;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic        div_busy;
  logic [63:0] div_q;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [16:0] mul_b;
  logic        mul_busy;
  logic [63:0] mul_p;

  // divide by five or ten
  logic        cd_start;
  logic        cd_ten;
  logic [43:0] cd_a;
  logic        cd_busy_r;
  logic [2:0]  cd_step_r;
  logic        cd_ten_r;
  logic [43:0] cd_n_r;
  logic [43:0] cd_q_r;
  logic [43:0] cd_d;
  logic [43:0] cd_prod;
  logic [43:0] cd_rem;
  logic [43:0] cd_fix;

  // combinational helpers
  logic [31:0] ns;
  logic [39:0] sample;
  logic [48:0] sum_add;
  logic [42:0] samp4;
  logic [42:0] peak5;
  logic [42:0] wmax5;
  logic [42:0] peak6;
  logic [39:0] elapsed;
  logic [39:0] cost;
  logic [39:0] us;
  logic [16:0] steady;
  logic [16:0] rising;
  logic [39:0] mean;
  logic        rise_win;
  logic [3:0]  hold_new;
  logic [39:0] blended;
  logic [63:0] maxf;
  logic [11:0] tgt_maxf;
  logic [11:0] tgt_cap;
  logic [11:0] sub;
  logic [19:0] pace_full;
  logic        out_free;

  fpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quot     (div_q)
  );

  fpg_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .busy   (mul_busy),
    .prod   (mul_p)
  );

  // sample and window arithmetic
  always_comb begin
    ns       = dur_r[31] ? 32'd0 : dur_r;
    sample   = {ns, 8'h00};
    sum_add  = {1'b0, wsum_r} + 49'(ns);
    samp4    = {1'b0, sample, 2'b00};
    peak5    = {1'b0, peak_r, 2'b00} + 43'(peak_r);
    wmax5    = {1'b0, wmax_r, 2'b00} + 43'(wmax_r);
    peak6    = {1'b0, peak_r, 2'b00} + {2'b00, peak_r, 1'b0};
    elapsed  = now_r - wstart_r;
    cost     = (peak_r > avg_r) ? peak_r : avg_r;
    us       = {1'b0, dur_r[30:0], 8'h00};
    steady   = steady_f(smooth_r);
    rising   = rising_f(smooth_r);
    mean     = (div_q > 64'(MASK40)) ? MASK40 : div_q[39:0];
    rise_win = (peak_r != '0) && (wmax5 > peak6);
    if (rise_win) hold_new = HOLD_WINDOWS;
    else if (hold_r != '0) hold_new = hold_r - 4'd1;
    else hold_new = '0;
    blended  = cd_q_r[39:0];
    maxf     = (div_q < 64'(nat_r)) ? 64'(nat_r) : div_q;
    tgt_maxf = (64'(tgt_in_r) < maxf) ? tgt_in_r : maxf[11:0];
    tgt_cap  = ((cap_r != '0) && (tgt_r > cap_r)) ? cap_r : tgt_r;
    sub      = (div_q == '0) ? 12'd1 : div_q[11:0];
    if (frc_r) sub = 12'd1;
    pace_full = sub * nat_r;
    out_free = !out_valid_r || !out_stall;
  end

  // unit launches
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cd_start  = 1'b0;
    cd_ten    = 1'b0;
    cd_a      = '0;
    case (cmd.op)
      DP_MEAN_GO: begin
        div_start = 1'b1;
        div_a     = 64'({wsum_r, 8'h00});
        div_b     = 64'(wcnt_r);
      end
      DP_CLOSE: begin
        cd_start = 1'b1;
        cd_ten   = 1'b0;
        cd_a     = 44'({peak_r, 1'b0}) + 44'(peak_r) + 44'({wmax_r, 1'b0});
      end
      DP_LOGIC: begin
        cd_start = sts.logic_div;
        cd_ten   = 1'b1;
        cd_a     = 44'(us) + 44'({lt_r, 3'b000}) + 44'(lt_r);
      end
      DP_PLAN: begin
        div_start = !sts.plan_direct;
        div_a     = NS_PER_S_Q8;
        div_b     = 64'(nat_r);
      end
      DP_TICK_FIN: begin
        mul_start = !sts.tick_le;
        mul_a     = 64'(div_q[39:0] - lt_r);
        mul_b     = safety_r;
      end
      DP_NUM_FIN: begin
        mul_start = !sts.num_lt;
        mul_a     = mul_p;
        mul_b     = 17'(nat_r);
      end
      DP_PROD_FIN: begin
        div_start = 1'b1;
        div_a     = mul_p;
        div_b     = 64'({cost, 16'h0000});
      end
      DP_CAP: begin
        div_start = 1'b1;
        div_a     = 64'(tgt_cap);
        div_b     = 64'(nat_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // divide by five or ten: series estimate of 0.8 x, scaled by 1/4 or 1/8, then one remainder fix
  always_comb begin
    cd_d    = cd_ten_r ? 44'd10 : 44'd5;
    cd_prod = cd_ten_r ? {cd_q_r[40:0], 3'b000} + {cd_q_r[42:0], 1'b0}
                       : {cd_q_r[41:0], 2'b00} + cd_q_r;
    cd_rem  = cd_n_r - cd_prod;
    cd_fix  = cd_q_r + 44'(cd_rem >= cd_d) + 44'(cd_rem >= {cd_d[42:0], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_busy_r <= 1'b0;
      cd_step_r <= '0;
    end else if (cd_start) begin
      cd_busy_r <= 1'b1;
      cd_step_r <= '0;
      cd_ten_r  <= cd_ten;
      cd_n_r    <= cd_a;
      cd_q_r    <= {1'b0, cd_a[43:1]} + {2'b00, cd_a[43:2]};
    end else if (cd_busy_r) begin
      cd_step_r <= cd_step_r + 3'd1;
      case (cd_step_r)
        3'd0: cd_q_r <= cd_q_r + {4'h0, cd_q_r[43:4]};
        3'd1: cd_q_r <= cd_q_r + {8'h00, cd_q_r[43:8]};
        3'd2: cd_q_r <= cd_q_r + {16'h0000, cd_q_r[43:16]};
        3'd3: cd_q_r <= cd_q_r + {32'h0000_0000, cd_q_r[43:32]};
        3'd4: cd_q_r <= cd_ten_r ? {3'b000, cd_q_r[43:3]} : {2'b00, cd_q_r[43:2]};
        default: begin
          cd_q_r    <= cd_fix;
          cd_busy_r <= 1'b0;
        end
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    sts.opcode      = opc_r;
    sts.close       = close_r;
    sts.logic_div   = !dur_r[31] && (lt_r != '0) && !(us > lt_r);
    sts.plan_direct = byp_r || (cost == '0);
    sts.tick_le     = div_q <= 64'(lt_r);
    sts.num_lt      = mul_p < 64'({cost, 16'h0000});
    sts.unit_busy   = div_busy || mul_busy || cd_busy_r;
    sts.out_free    = out_free;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= SMOOTH_RESET;
      win_r    <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SMOOTHNESS: smooth_r <= cfg_wdata[16:0];
        CFG_WINDOW_US:  win_r    <= cfg_wdata;
        default:        win_r    <= win_r;
      endcase
    end
  end

  // input capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      opc_r    <= in_opcode;
      dur_r    <= in_duration_ns;
      now_r    <= in_now_us;
      tgt_in_r <= in_target_fps;
      nat_r    <= (in_native_fps == '0) ? 8'd1 : in_native_fps;
      cap_r    <= in_hard_cap_fps;
      byp_r    <= in_bypass_budget;
      frc_r    <= in_force_native;
    end
  end

  // governor state and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r      <= '0;
      peak_r     <= '0;
      lt_r       <= '0;
      wsum_r     <= '0;
      wcnt_r     <= '0;
      wmax_r     <= '0;
      wstart_r   <= '0;
      safety_r   <= steady_f(SMOOTH_RESET);
      hold_r     <= '0;
      close_r    <= 1'b0;
      res_plan_r <= 1'b0;
    end else begin
      case (cmd.op)
        DP_LOAD: begin
          res_plan_r <= 1'b0;
          res_sub_r  <= '0;
          res_pace_r <= '0;
        end
        DP_COST: begin
          wsum_r  <= sum_add[48] ? MASK48 : sum_add[47:0];
          if (wcnt_r != COUNT_MAX) wcnt_r <= wcnt_r + 24'd1;
          if (sample > wmax_r) wmax_r <= sample;
          if (peak_r == '0) begin
            peak_r   <= sample;
            safety_r <= rising;
            hold_r   <= HOLD_WINDOWS;
          end else if (samp4 > peak5) begin
            peak_r   <= 40'(({1'b0, sample} + {1'b0, peak_r}) >> 1);
            safety_r <= rising;
            hold_r   <= HOLD_WINDOWS;
          end
          close_r <= elapsed >= 40'(win_r);
        end
        DP_CLOSE: begin
          avg_r    <= (avg_r == '0) ? mean : 40'(({1'b0, mean} + {1'b0, avg_r}) >> 1);
          hold_r   <= hold_new;
          safety_r <= (hold_new != '0) ? rising : steady;
        end
        DP_BLEND_FIN: begin
          peak_r   <= (wmax_r > blended) ? wmax_r : blended;
          wsum_r   <= '0;
          wcnt_r   <= '0;
          wmax_r   <= '0;
          wstart_r <= now_r;
        end
        DP_LOGIC: begin
          if (!dur_r[31]) begin
            if (lt_r == '0) lt_r <= us;
            else if (us > lt_r) lt_r <= 40'(({1'b0, us} + {1'b0, lt_r}) >> 1);
          end
        end
        DP_LOGIC_FIN: lt_r <= cd_q_r[39:0];
        DP_PLAN: begin
          if (sts.plan_direct) tgt_r <= tgt_in_r;
        end
        DP_TICK_FIN: begin
          if (sts.tick_le) tgt_r <= 12'(nat_r);
        end
        DP_NUM_FIN: begin
          if (sts.num_lt) tgt_r <= 12'(nat_r);
        end
        DP_MAXF_FIN: tgt_r <= tgt_maxf;
        DP_CAP: tgt_r <= tgt_cap;
        DP_SUB_FIN: begin
          res_plan_r <= 1'b1;
          res_sub_r  <= sub;
          res_pace_r <= pace_full[11:0];
        end
        DP_RESET: begin
          avg_r    <= '0;
          peak_r   <= '0;
          lt_r     <= '0;
          wsum_r   <= '0;
          wcnt_r   <= '0;
          wmax_r   <= '0;
          wstart_r <= now_r;
          safety_r <= steady;
          hold_r   <= '0;
        end
        default: begin
          close_r <= close_r;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid_r <= 1'b1;
      out_plan_r  <= res_plan_r;
      out_sub_r   <= res_sub_r;
      out_pace_r  <= res_pace_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plan_valid = out_plan_r;
  assign out_subframes  = out_sub_r;
  assign out_pace_fps   = out_pace_r;

endmodule

>>> rtl/fpg_ctrl.sv
// Controller: sequences one word through the datapath steps.
// Depends on fpg_pkg and frame_pacing_governor_assert.svh.
`timescale 1ns / 1ps
`include "frame_pacing_governor_assert.svh"
module fpg_ctrl import fpg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;
  ctl_state_t ret_r, ret_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd.op    = DP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.opcode)
          OPC_COST:  state_nxt = ST_COST;
          OPC_LOGIC: state_nxt = ST_LOGIC;
          OPC_PLAN:  state_nxt = ST_PLAN;
          default:   state_nxt = ST_RESET;
        endcase
      end
      ST_COST: begin
        cmd.op    = DP_COST;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = sts.close ? ST_MEAN : ST_EMIT;
      ST_MEAN: begin
        cmd.op    = DP_MEAN_GO;
        ret_nxt   = ST_CLOSE;
        state_nxt = ST_WAIT;
      end
      ST_CLOSE: begin
        cmd.op    = DP_CLOSE;
        ret_nxt   = ST_BLEND;
        state_nxt = ST_WAIT;
      end
      ST_BLEND: begin
        cmd.op    = DP_BLEND_FIN;
        state_nxt = ST_EMIT;
      end
      ST_LOGIC: begin
        cmd.op = DP_LOGIC;
        if (sts.logic_div) begin
          ret_nxt   = ST_LOGIC_FIN;
          state_nxt = ST_WAIT;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_LOGIC_FIN: begin
        cmd.op    = DP_LOGIC_FIN;
        state_nxt = ST_EMIT;
      end
      ST_PLAN: begin
        cmd.op = DP_PLAN;
        if (sts.plan_direct) begin
          state_nxt = ST_CAP;
        end else begin
          ret_nxt   = ST_TICK;
          state_nxt = ST_WAIT;
        end
      end
      ST_TICK: begin
        cmd.op = DP_TICK_FIN;
        if (sts.tick_le) begin
          state_nxt = ST_CAP;
        end else begin
          ret_nxt   = ST_NUM;
          state_nxt = ST_WAIT;
        end
      end
      ST_NUM: begin
        cmd.op = DP_NUM_FIN;
        if (sts.num_lt) begin
          state_nxt = ST_CAP;
        end else begin
          ret_nxt   = ST_PROD;
          state_nxt = ST_WAIT;
        end
      end
      ST_PROD: begin
        cmd.op    = DP_PROD_FIN;
        ret_nxt   = ST_MAXF;
        state_nxt = ST_WAIT;
      end
      ST_MAXF: begin
        cmd.op    = DP_MAXF_FIN;
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        cmd.op    = DP_CAP;
        ret_nxt   = ST_SUB;
        state_nxt = ST_WAIT;
      end
      ST_SUB: begin
        cmd.op    = DP_SUB_FIN;
        state_nxt = ST_EMIT;
      end
      ST_RESET: begin
        cmd.op    = DP_RESET;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = DP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (!sts.unit_busy) state_nxt = ret_r;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  // a launched unit is busy on the first wait cycle
  `FPG_ASSERT_NEXT(a_wait_busy, state_r != ST_WAIT && state_nxt == ST_WAIT, sts.unit_busy)
  // an accepted word goes to decode
  `FPG_ASSERT_NEXT(a_accept_decode, in_valid && !in_stall, state_r == ST_DECODE)
  // an emitted result returns the controller to idle
  `FPG_ASSERT_NEXT(a_emit_idle, cmd.op == DP_EMIT, state_r == ST_IDLE && !in_stall)

endmodule

>>> rtl/frame_pacing_governor.sv
// Frame pacing governor: cost, logic time, plan and reset words in, one result out.
// Channels: in_* carries one word (opcode plus fields) under valid/stall;
//   out_* returns exactly one result word per input word, in order.
// Configuration: cfg_we writes smoothness (index 0) or window_us (index 1);
//   the user must write only while the block is idle; the block does not enforce it.
// Units: a plan word always uses the shared restoring divider (up to three
//   passes per plan) and, unless the budget is skipped, the shift-add
//   multiplier (up to two passes per plan); a cost word that closes a window
//   uses the divider and the divide by five or ten, which a logic word also
//   uses when it blends its logic time.
// Throughput: one word at a time; in_stall is high from acceptance until the
//   result is loaded into the output register.
// Reset: synchronous, active low; clears the governor state and restores the
//   register defaults; safety starts at the steady fraction.
// Receiver stall: the result holds in the output register; the next word can
//   be accepted and worked on, and waits only to hand over its result.
// Depends on fpg_pkg, fpg_ctrl, fpg_datapath.
`timescale 1ns / 1ps
module frame_pacing_governor import fpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_duration_ns,
  input  logic [39:0] in_now_us,
  input  logic [11:0] in_target_fps,
  input  logic [7:0]  in_native_fps,
  input  logic [11:0] in_hard_cap_fps,
  input  logic        in_bypass_budget,
  input  logic        in_force_native,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_plan_valid,
  output logic [11:0] out_subframes,
  output logic [11:0] out_pace_fps
);

  cmd_t    cmd;
  status_t sts;

  // sequencing
  fpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and state
  fpg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_opcode        (in_opcode),
    .in_duration_ns   (in_duration_ns),
    .in_now_us        (in_now_us),
    .in_target_fps    (in_target_fps),
    .in_native_fps    (in_native_fps),
    .in_hard_cap_fps  (in_hard_cap_fps),
    .in_bypass_budget (in_bypass_budget),
    .in_force_native  (in_force_native),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plan_valid   (out_plan_valid),
    .out_subframes    (out_subframes),
    .out_pace_fps     (out_pace_fps)
  );

endmodule
